FILE: design/dnsd_pkg.sv
// ----------------------------------------------------------------------------
// dnsd_pkg
// Shared constants and types for the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnsd_pkg;

    localparam int MSG_BYTES   = 512;
    localparam int NAME_BYTES  = 256;

    localparam int ADDR_W  = $clog2(MSG_BYTES);
    localparam int WALK_W  = ADDR_W + 1;
    localparam int NEXT_W  = 10;
    localparam int NAME_W  = $clog2(NAME_BYTES);
    localparam int JLIM_W  = 6;
    localparam int JCNT_W  = JLIM_W + 1;
    localparam int PTR_W   = 14;

    localparam logic [NAME_W-1:0] NAME_CAP   = NAME_W'(NAME_BYTES - 1);
    localparam logic [WALK_W-1:0] WALK_MAX   = WALK_W'(MSG_BYTES);
    localparam logic [JLIM_W-1:0] JUMP_LIMIT_RESET = 6'd20;

    localparam logic [7:0] PTR_MARK      = 8'hC0;
    localparam logic [7:0] PTR_HIGH_MASK = 8'h3F;
    localparam logic [7:0] DOT_CHAR      = 8'h2E;

    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // walker -> packer
    typedef struct packed {
        logic              char_valid;
        logic [7:0]        char_data;
        logic              fin_valid;
        logic              fin_err;
        logic [NEXT_W-1:0] fin_next;
    } dnsd_wp_t;

    // packer -> walker
    typedef struct packed {
        logic char_ready;
        logic fin_ready;
    } dnsd_pw_t;

endpackage

FILE: design/dns_name_decompressor_top.sv
// Store: an accepted store item writes its byte into the message store. A decode
//   reads and examines each length byte, reads the low pointer byte and jumps on a
//   pointer, streams each label byte with a dot between labels, then gives a result.
// Throughput: one store item per cycle while idle; one decode at a time, the next is
//   taken once the final result is in the output register. Result stalls hold the walk.
// Reset: synchronous, active low; clears control, jump_limit to 20; bytes not cleared.
// ----------------------------------------------------------------------------
// dns_name_decompressor_top
// Walks compressed DNS names in a loaded message and streams the characters.
// ----------------------------------------------------------------------------
module dns_name_decompressor_top import dnsd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [JLIM_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [7:0]        s_byte_value,
    input  logic [ADDR_W-1:0] s_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_name_chars,
    output logic [2:0]        m_char_count,
    output logic              m_status,
    output logic [NEXT_W-1:0] m_next_offset,
    output logic              m_last
);

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;
    dnsd_wp_t          wp;
    dnsd_pw_t          pw;

    dnsd_msg_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    dnsd_walker u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_byte_value (s_byte_value),
        .s_position   (s_position),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .wp           (wp),
        .pw           (pw)
    );

    dnsd_packer u_packer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wp            (wp),
        .pw            (pw),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_name_chars  (m_name_chars),
        .m_char_count  (m_char_count),
        .m_status      (m_status),
        .m_next_offset (m_next_offset),
        .m_last        (m_last)
    );

endmodule

FILE: design/dnsd_msg_ram.sv
// ----------------------------------------------------------------------------
// dnsd_msg_ram
// Message byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dnsd_msg_ram import dnsd_pkg::*; (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [MSG_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/dnsd_walker.sv
// ----------------------------------------------------------------------------
// dnsd_walker
// Input handshake, store writes and the label / pointer walk sequencer.
// ----------------------------------------------------------------------------
module dnsd_walker import dnsd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [JLIM_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [7:0]        s_byte_value,
    input  logic [ADDR_W-1:0] s_position,
    output logic              ram_wr_en,
    output logic [ADDR_W-1:0] ram_wr_addr,
    output logic [7:0]        ram_wr_data,
    output logic              ram_rd_en,
    output logic [ADDR_W-1:0] ram_rd_addr,
    input  logic [7:0]        ram_rd_data,
    output dnsd_wp_t          wp,
    input  dnsd_pw_t          pw
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LEN_RD = 3'd1;
    localparam logic [2:0] ST_LEN_WT = 3'd2;
    localparam logic [2:0] ST_PTR_WT = 3'd3;
    localparam logic [2:0] ST_LABEL  = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [JLIM_W-1:0] jlim_reg, jlim_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [NEXT_W-1:0] next_reg, next_next;
    logic [JCNT_W-1:0] jumps_reg, jumps_next;
    logic [WALK_W-1:0] walk_reg, walk_next;
    logic [NAME_W-1:0] n_reg, n_next;
    logic [7:0]        rem_reg, rem_next;
    logic [5:0]        hi_reg, hi_next;
    logic              jumped_reg, jumped_next;
    logic              err_reg, err_next;
    logic              dot_reg, dot_next;
    logic              pend_reg, pend_next;

    logic              accept;
    logic              keep;
    logic              advance;
    logic [PTR_W-1:0]  ptr_target;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign ram_wr_en   = accept && (s_cmd == CMD_STORE);
    assign ram_wr_addr = s_position;
    assign ram_wr_data = s_byte_value;

    assign keep       = (n_reg < NAME_CAP);
    assign advance    = !pend_reg || !keep || pw.char_ready;
    assign ptr_target = {hi_reg, ram_rd_data};

    always_comb begin
        state_next  = state_reg;
        jlim_next   = jlim_reg;
        cur_next    = cur_reg;
        next_next   = next_reg;
        jumps_next  = jumps_reg;
        walk_next   = walk_reg;
        n_next      = n_reg;
        rem_next    = rem_reg;
        hi_next     = hi_reg;
        jumped_next = jumped_reg;
        err_next    = err_reg;
        dot_next    = dot_reg;
        pend_next   = pend_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cur_reg;
        wp          = '0;

        if (cfg_wr_en) begin
            jlim_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_cmd == CMD_DECODE)) begin
                    cur_next    = s_position;
                    next_next   = '0;
                    jumps_next  = '0;
                    walk_next   = '0;
                    n_next      = '0;
                    jumped_next = 1'b0;
                    err_next    = 1'b0;
                    dot_next    = 1'b0;
                    pend_next   = 1'b0;
                    state_next  = ST_LEN_RD;
                end
            end
            ST_LEN_RD: begin
                if ((jumps_reg > {1'b0, jlim_reg}) || (walk_reg > WALK_MAX)) begin
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cur_reg;
                    walk_next   = walk_reg + 1'b1;
                    state_next  = ST_LEN_WT;
                end
            end
            ST_LEN_WT: begin
                if (ram_rd_data == 8'd0) begin
                    if (!jumped_reg) begin
                        next_next = NEXT_W'(cur_reg) + 1'b1;
                    end
                    state_next = ST_FIN;
                end else if ((ram_rd_data & PTR_MARK) == PTR_MARK) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cur_reg + 1'b1;
                    hi_next     = 6'(ram_rd_data & PTR_HIGH_MASK);
                    state_next  = ST_PTR_WT;
                end else begin
                    cur_next   = cur_reg + 1'b1;
                    rem_next   = ram_rd_data;
                    dot_next   = (n_reg != '0) && keep;
                    pend_next  = 1'b0;
                    state_next = ST_LABEL;
                end
            end
            ST_PTR_WT: begin
                if (!jumped_reg) begin
                    next_next   = NEXT_W'(cur_reg) + NEXT_W'(2);
                    jumped_next = 1'b1;
                end
                cur_next   = ptr_target[ADDR_W-1:0];
                jumps_next = jumps_reg + 1'b1;
                walk_next  = '0;
                state_next = ST_LEN_RD;
            end
            ST_LABEL: begin
                if (dot_reg) begin
                    wp.char_valid = 1'b1;
                    wp.char_data  = DOT_CHAR;
                    if (pw.char_ready) begin
                        dot_next = 1'b0;
                        n_next   = n_reg + 1'b1;
                    end
                end else begin
                    // rd_data holds a label char while pend is set
                    wp.char_valid = pend_reg && keep;
                    wp.char_data  = ram_rd_data;
                    if (pend_reg && keep && pw.char_ready) begin
                        n_next = n_reg + 1'b1;
                    end
                    if (advance) begin
                        if (rem_reg != 8'd0) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = cur_reg;
                            cur_next    = cur_reg + 1'b1;
                            rem_next    = rem_reg - 1'b1;
                            pend_next   = 1'b1;
                        end else begin
                            pend_next  = 1'b0;
                            state_next = ST_LEN_RD;
                        end
                    end
                end
            end
            ST_FIN: begin
                wp.fin_valid = 1'b1;
                wp.fin_err   = err_reg;
                wp.fin_next  = next_reg;
                if (pw.fin_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            jlim_reg  <= JUMP_LIMIT_RESET;
            dot_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            jlim_reg  <= jlim_next;
            dot_reg   <= dot_next;
            pend_reg  <= pend_next;
        end
        cur_reg    <= cur_next;
        next_reg   <= next_next;
        jumps_reg  <= jumps_next;
        walk_reg   <= walk_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        hi_reg     <= hi_next;
        jumped_reg <= jumped_next;
        err_reg    <= err_next;
    end

endmodule

FILE: design/dnsd_packer.sv
// ----------------------------------------------------------------------------
// dnsd_packer
// Packs name characters up to four to a result and holds the output register.
// ----------------------------------------------------------------------------
module dnsd_packer import dnsd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dnsd_wp_t          wp,
    output dnsd_pw_t          pw,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_name_chars,
    output logic [2:0]        m_char_count,
    output logic              m_status,
    output logic [NEXT_W-1:0] m_next_offset,
    output logic              m_last
);

    logic [31:0]       word_reg, word_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       chars_reg, chars_next;
    logic [2:0]        count_reg, count_next;
    logic              status_reg, status_next;
    logic [NEXT_W-1:0] noff_reg, noff_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              push;

    assign out_free      = !m_valid_reg || m_ready;
    assign pw.char_ready = (cnt_reg != 3'd4) || out_free;
    assign pw.fin_ready  = out_free;

    always_comb begin
        word_next   = word_reg;
        cnt_next    = cnt_reg;
        push        = 1'b0;
        chars_next  = chars_reg;
        count_next  = count_reg;
        status_next = status_reg;
        noff_next   = noff_reg;
        last_next   = last_reg;

        if (wp.char_valid && pw.char_ready) begin
            // a full word goes out as not last only once a later char arrives; else fin sends it
            if (cnt_reg == 3'd4) begin
                push        = 1'b1;
                chars_next  = word_reg;
                count_next  = 3'd4;
                status_next = 1'b0;
                noff_next   = '0;
                last_next   = 1'b0;
            end
            if ((cnt_reg == 3'd0) || (cnt_reg == 3'd4)) begin
                word_next = {24'd0, wp.char_data};
                cnt_next  = 3'd1;
            end else begin
                word_next[8*cnt_reg[1:0] +: 8] = wp.char_data;
                cnt_next = cnt_reg + 1'b1;
            end
        end else if (wp.fin_valid && pw.fin_ready) begin
            push        = 1'b1;
            chars_next  = (cnt_reg == 3'd0) ? 32'd0 : word_reg;
            count_next  = cnt_reg;
            status_next = wp.fin_err;
            noff_next   = wp.fin_err ? '0 : wp.fin_next;
            last_next   = 1'b1;
            cnt_next    = 3'd0;
        end

        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        word_reg   <= word_next;
        chars_reg  <= chars_next;
        count_reg  <= count_next;
        status_reg <= status_next;
        noff_reg   <= noff_next;
        last_reg   <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_name_chars  = chars_reg;
    assign m_char_count  = count_reg;
    assign m_status      = status_reg;
    assign m_next_offset = noff_reg;
    assign m_last        = last_reg;

endmodule
